>>> rtl/sdcf_pkg.sv
// Package: payload types, datagram constants and CRC8 helper for the config framer.
`default_nettype none
package sdcf_pkg;

  localparam logic [7:0]  SYNC_BYTE    = 8'h05;
  localparam logic [7:0]  WRITE_FLAG   = 8'h80;
  localparam logic [7:0]  CRC_POLY     = 8'h07;
  localparam logic [7:0]  REG_GLOBAL   = 8'h00;
  localparam logic [7:0]  REG_CHOPPER  = 8'h6C;
  localparam logic [7:0]  REG_CURRENT  = 8'h10;
  localparam logic [31:0] GLOBAL_DATA  = 32'h0000_00C1;
  localparam logic [31:0] CHOPPER_BASE = 32'h1000_0053;
  localparam logic [7:0]  HOLD_DELAY   = 8'h06;
  localparam logic [3:0]  CODE_DEFAULT = 4'd4;

  localparam logic [1:0]  FRM_GLOBAL   = 2'd0;
  localparam logic [1:0]  FRM_CHOPPER  = 2'd1;
  localparam logic [1:0]  FRM_CURRENT  = 2'd2;

  localparam logic [2:0]  POS_SYNC     = 3'd0;
  localparam logic [2:0]  POS_ADDR     = 3'd1;
  localparam logic [2:0]  POS_REG      = 3'd2;
  localparam logic [2:0]  POS_D3       = 3'd3;
  localparam logic [2:0]  POS_D2       = 3'd4;
  localparam logic [2:0]  POS_D1       = 3'd5;
  localparam logic [2:0]  POS_D0       = 3'd6;
  localparam logic [2:0]  POS_CRC      = 3'd7;

  localparam logic [4:0]  LAST_BYTE    = 5'd23;

  typedef struct packed {
    logic [7:0]  node_address;
    logic [15:0] microstep_count;
    logic [7:0]  run_current;
    logic [7:0]  hold_current;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [3:0] code;
    logic [4:0] run;
    logic [4:0] hold;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[7] ^ data_in[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/sdcf_front.sv
// Front end: classifies a request into a compact job (resolution code, masked currents).
`default_nettype none
module sdcf_front
  import sdcf_pkg::*;
(
  input  wire in_t  req,
  output job_t      job
);

  logic [3:0] code;

  always_comb begin
    case (req.microstep_count)
      16'd256: code = 4'd0;
      16'd128: code = 4'd1;
      16'd64:  code = 4'd2;
      16'd32:  code = 4'd3;
      16'd16:  code = 4'd4;
      16'd8:   code = 4'd5;
      16'd4:   code = 4'd6;
      16'd2:   code = 4'd7;
      16'd1:   code = 4'd8;
      default: code = CODE_DEFAULT;
    endcase
  end

  always_comb begin
    job.addr = req.node_address;
    job.code = code;
    job.run  = req.run_current[4:0];
    job.hold = req.hold_current[4:0];
  end

endmodule
`default_nettype wire

>>> rtl/sdcf_queue.sv
// Two-entry job queue between the classifier and the datagram sequencer.
`default_nettype none
module sdcf_queue
  import sdcf_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       push,
  input  wire job_t push_job,
  output logic      full,
  input  wire       pop,
  output logic      head_valid,
  output job_t      head_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sdcf_back.sv
// Back end: walks 24 datagram bytes per job, running CRC8, registered output.
`default_nettype none
module sdcf_back
  import sdcf_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      out_valid,
  input  wire       out_ready,
  output out_t      out_data
);

  logic [4:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r;
  logic        advance;
  logic [1:0]  frm;
  logic [2:0]  pos;
  logic [7:0]  reg_byte;
  logic [31:0] data;
  logic [7:0]  byte_val;
  logic [7:0]  crc_base;

  assign frm       = cnt_r[4:3];
  assign pos       = cnt_r[2:0];
  assign advance   = job_valid && (!out_valid_r || out_ready);
  assign job_pop   = advance && (cnt_r == LAST_BYTE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (frm)
      FRM_GLOBAL: begin
        reg_byte = REG_GLOBAL;
        data     = GLOBAL_DATA;
      end
      FRM_CHOPPER: begin
        reg_byte = REG_CHOPPER;
        data     = CHOPPER_BASE | {4'h0, job.code, 24'h00_0000};
      end
      FRM_CURRENT: begin
        reg_byte = REG_CURRENT;
        data     = {8'h00, HOLD_DELAY, 3'b000, job.run, 3'b000, job.hold};
      end
      default: begin
        reg_byte = REG_GLOBAL;
        data     = GLOBAL_DATA;
      end
    endcase
  end

  always_comb begin
    case (pos)
      POS_SYNC: byte_val = SYNC_BYTE;
      POS_ADDR: byte_val = job.addr;
      POS_REG:  byte_val = reg_byte | WRITE_FLAG;
      POS_D3:   byte_val = data[31:24];
      POS_D2:   byte_val = data[23:16];
      POS_D1:   byte_val = data[15:8];
      POS_D0:   byte_val = data[7:0];
      POS_CRC:  byte_val = crc_r;
      default:  byte_val = SYNC_BYTE;
    endcase
  end

  always_comb begin
    crc_base      = (pos == POS_SYNC) ? 8'h00 : crc_r;
    crc_nxt       = crc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      crc_nxt       = crc8_byte(crc_base, byte_val);
      cnt_nxt       = (cnt_r == LAST_BYTE) ? 5'd0 : cnt_r + 5'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (advance) begin
      out_r.tx_byte   <= byte_val;
      out_r.frame_end <= (pos == POS_CRC);
      out_r.last      <= (cnt_r == LAST_BYTE);
    end
  end

endmodule
`default_nettype wire

>>> rtl/stepper_driver_config_framer.sv
// Top level: stepper driver config framer, three CRC8 write datagrams per request.
// A request passes through the job queue and then the registered output stage of the byte sequencer.
// One byte per cycle while out_ready allows, 24 bytes per request, set by the byte sequencer.
// A two-entry job queue holds the request being sent plus one waiting request.
// Reset (synchronous, rst_n low) empties the queue, the byte counter and the output.
`default_nettype none
module stepper_driver_config_framer
  import sdcf_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  input  wire in_t in_data,
  output logic     out_valid,
  input  wire      out_ready,
  output out_t     out_data
);

  job_t q_in_job;
  job_t q_head_job;
  logic q_full;
  logic q_head_valid;
  logic q_pop;

  assign in_ready = !q_full;

  sdcf_front u_front (
    .req (in_data),
    .job (q_in_job)
  );

  sdcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && in_ready),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  sdcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_head_valid),
    .job       (q_head_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
